/* rtl/core/b64d_pkg.sv */
// b64d_pkg: shared types, codes and character decode for the base64 stream decoder
// no dependencies
`default_nettype none

package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] STATUS_DATA  = 2'd0;
    localparam logic [1:0] STATUS_END   = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [1:0] MODE_STD = 2'd1;
    localparam logic [1:0] MODE_URL = 2'd2;

    localparam logic [1:0] LOCK_NONE = 2'd0;
    localparam logic [1:0] LOCK_STD  = 2'd1;
    localparam logic [1:0] LOCK_URL  = 2'd2;

    localparam logic [1:0] REG_ALPHABET_MODE   = 2'd0;
    localparam logic [1:0] REG_SKIP_WHITESPACE = 2'd1;
    localparam logic [1:0] REG_REPORT_ERRORS   = 2'd2;

    localparam logic ACT_END = 1'b1;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    typedef struct packed {
        logic [1:0] byte_count;
        logic       has_stop;
        logic [1:0] stop_status;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } job_t;

    typedef struct packed {
        logic       valid;
        logic       is_std;
        logic       is_url;
        logic [5:0] value;
    } sym_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic sym_t map_char(input logic [7:0] c);
        sym_t s;
        s = '0;
        if ((c >= 8'h41) && (c <= 8'h5A)) begin
            s.valid = 1'b1;
            s.value = 6'(c - 8'h41);
        end else if ((c >= 8'h61) && (c <= 8'h7A)) begin
            s.valid = 1'b1;
            s.value = 6'(c - 8'h47);
        end else if ((c >= 8'h30) && (c <= 8'h39)) begin
            s.valid = 1'b1;
            s.value = 6'(c + 8'h04);
        end else if ((c == 8'h2B) || (c == 8'h2F)) begin
            s.valid  = 1'b1;
            s.is_std = 1'b1;
            s.value  = (c == 8'h2B) ? 6'h3E : 6'h3F;
        end else if ((c == 8'h2D) || (c == 8'h5F)) begin
            s.valid  = 1'b1;
            s.is_url = 1'b1;
            s.value  = (c == 8'h2D) ? 6'h3E : 6'h3F;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/b64d_front.sv */
// b64d_front: accepts characters, tracks group state and alphabet lock, builds result jobs
// depends on b64d_pkg
`default_nettype none

module b64d_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_action,
    input  wire logic [7:0]   s_char_byte,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [1:0]   cfg_data,
    input  wire logic         queue_full,
    output logic              push_valid,
    output b64d_pkg::job_t    push_job
);

    logic       skip_ws_reg;
    logic       report_reg;
    logic [1:0] lock_reg, lock_next;
    logic [2:0] sym_count_reg, sym_count_next;
    logic [1:0] pad_count_reg, pad_count_next;
    logic       halted_reg, halted_next;
    logic [5:0] quad_reg [3];

    logic             accept;
    logic [1:0]       err_status;
    logic             flush_ok;
    logic [1:0]       flush_bytes;
    logic [2:0]       pos_sum;
    logic             sym_ok;
    logic             store_sym;
    b64d_pkg::sym_t   sym;

    assign s_ready   = !queue_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    assign sym        = b64d_pkg::map_char(s_char_byte);
    assign err_status = report_reg ? b64d_pkg::STATUS_ERROR : b64d_pkg::STATUS_END;
    assign sym_ok     = sym.valid
                        && !(sym.is_std && (lock_reg == b64d_pkg::LOCK_URL))
                        && !(sym.is_url && (lock_reg == b64d_pkg::LOCK_STD));
    assign pos_sum    = sym_count_reg + {1'b0, pad_count_reg};

    assign flush_ok = !(sym_count_reg == 3'd1)
                      && !((sym_count_reg == 3'd3) && (quad_reg[2][1:0] != 2'b00));

    always_comb begin
        unique case (sym_count_reg)
            3'd2:    flush_bytes = 2'd1;
            3'd3:    flush_bytes = 2'd2;
            3'd4:    flush_bytes = 2'd3;
            default: flush_bytes = 2'd0;
        endcase
    end

    always_comb begin
        lock_next      = lock_reg;
        sym_count_next = sym_count_reg;
        pad_count_next = pad_count_reg;
        halted_next    = halted_reg;
        store_sym      = 1'b0;
        push_valid     = 1'b0;
        push_job.byte_count  = 2'd0;
        push_job.has_stop    = 1'b0;
        push_job.stop_status = err_status;
        push_job.byte0 = {quad_reg[0], quad_reg[1][5:4]};
        push_job.byte1 = {quad_reg[1][3:0], quad_reg[2][5:2]};
        push_job.byte2 = {quad_reg[2][1:0], sym.value};

        if (accept && !halted_reg) begin
            if (s_action == b64d_pkg::ACT_END) begin
                push_valid        = 1'b1;
                push_job.has_stop = 1'b1;
                halted_next       = 1'b1;
                sym_count_next    = 3'd0;
                pad_count_next    = 2'd0;
                if (flush_ok) begin
                    push_job.byte_count  = flush_bytes;
                    push_job.stop_status = (pad_count_reg != 2'd0) ? err_status
                                                                   : b64d_pkg::STATUS_END;
                end
            end else if (skip_ws_reg && b64d_pkg::is_space(s_char_byte)) begin
                push_valid = 1'b0;
            end else if (s_char_byte == b64d_pkg::CHAR_PAD) begin
                if (sym_count_reg < 3'd2) begin
                    push_valid        = 1'b1;
                    push_job.has_stop = 1'b1;
                    halted_next       = 1'b1;
                    sym_count_next    = 3'd0;
                    pad_count_next    = 2'd0;
                end else if (pos_sum >= 3'd3) begin
                    push_valid     = 1'b1;
                    sym_count_next = 3'd0;
                    pad_count_next = 2'd0;
                    if (flush_ok) begin
                        push_job.byte_count = flush_bytes;
                    end else begin
                        push_job.has_stop = 1'b1;
                        halted_next       = 1'b1;
                    end
                end else begin
                    pad_count_next = pad_count_reg + 2'd1;
                end
            end else if ((pad_count_reg != 2'd0) || !sym_ok) begin
                push_valid          = 1'b1;
                push_job.has_stop   = 1'b1;
                push_job.byte_count = flush_ok ? flush_bytes : 2'd0;
                halted_next         = 1'b1;
                sym_count_next      = 3'd0;
                pad_count_next      = 2'd0;
            end else begin
                if (sym.is_std) begin
                    lock_next = b64d_pkg::LOCK_STD;
                end else if (sym.is_url) begin
                    lock_next = b64d_pkg::LOCK_URL;
                end
                if (sym_count_reg == 3'd3) begin
                    push_valid          = 1'b1;
                    push_job.byte_count = 2'd3;
                    sym_count_next      = 3'd0;
                end else begin
                    store_sym      = 1'b1;
                    sym_count_next = sym_count_reg + 3'd1;
                end
            end
        end

        if (cfg_valid && (cfg_index == b64d_pkg::REG_ALPHABET_MODE)) begin
            unique case (cfg_data)
                b64d_pkg::MODE_STD: lock_next = b64d_pkg::LOCK_STD;
                b64d_pkg::MODE_URL: lock_next = b64d_pkg::LOCK_URL;
                default:            lock_next = b64d_pkg::LOCK_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_ws_reg   <= 1'b0;
            report_reg    <= 1'b0;
            lock_reg      <= b64d_pkg::LOCK_NONE;
            sym_count_reg <= 3'd0;
            pad_count_reg <= 2'd0;
            halted_reg    <= 1'b0;
        end else begin
            lock_reg      <= lock_next;
            sym_count_reg <= sym_count_next;
            pad_count_reg <= pad_count_next;
            halted_reg    <= halted_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    b64d_pkg::REG_SKIP_WHITESPACE: skip_ws_reg <= cfg_data[0];
                    b64d_pkg::REG_REPORT_ERRORS:   report_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // symbol store, no reset needed
    always_ff @(posedge aclk) begin
        if (store_sym) begin
            quad_reg[sym_count_reg[1:0]] <= sym.value;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/b64d_queue.sv */
// b64d_queue: small job queue between the front and back parts
// depends on b64d_pkg
`default_nettype none

module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    input  b64d_pkg::job_t      push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output b64d_pkg::job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::job_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/b64d_back.sv */
// b64d_back: unpacks queued jobs into result words through an output register
// depends on b64d_pkg
`default_nettype none

module b64d_back (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         head_valid,
    input  b64d_pkg::job_t    head_job,
    output logic              pop,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_out_byte,
    output logic [1:0]        m_status,
    output logic              m_last
);

    logic       m_valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] status_reg, status_next;
    logic       last_reg, last_next;
    logic [1:0] idx_reg;
    logic       advance;

    assign advance = head_valid && (!m_valid_reg || m_ready);
    assign pop     = advance && last_next;

    always_comb begin
        if (idx_reg < head_job.byte_count) begin
            status_next = b64d_pkg::STATUS_DATA;
            unique case (idx_reg)
                2'd0:    byte_next = head_job.byte0;
                2'd1:    byte_next = head_job.byte1;
                default: byte_next = head_job.byte2;
            endcase
        end else begin
            status_next = head_job.stop_status;
            byte_next   = 8'd0;
        end
        last_next = head_job.has_stop ? (idx_reg == head_job.byte_count)
                                      : (idx_reg == head_job.byte_count - 2'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            if (advance) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= last_next ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_reg   <= byte_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = byte_reg;
    assign m_status   = status_reg;
    assign m_last     = last_reg;

endmodule

`default_nettype wire

/* rtl/core/base64_stream_decoder.sv */
// base64_stream_decoder: top level, front classifier, job queue and result back end
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
// throughput: one character word per cycle while the queue is not full
// results leave at one word per cycle while m_ready is high
// a full group's three bytes pass the queue, then the single output register, in turn
// reset: synchronous active-low aresetn clears group state, halt flag, queue and registers
`default_nettype none

module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [7:0]  s_char_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic [1:0]       m_status,
    output logic             m_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [1:0]  cfg_data
);

    logic           push_valid;
    b64d_pkg::job_t push_job;
    logic           queue_full;
    logic           pop;
    logic           head_valid;
    b64d_pkg::job_t head_job;

    b64d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_char_byte (s_char_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_full  (queue_full),
        .push_valid  (push_valid),
        .push_job    (push_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_status   (m_status),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

/* verif/base64_stream_decoder_checker.sv */
`timescale 1ns / 1ps
// base64_stream_decoder_checker: watches the character, result and register channels,
// predicts the decoded words of every accepted character and compares them in order
// depends on b64d_pkg for status, register, mode, lock, action and pad codes

module base64_stream_decoder_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic       s_action,
    input  wire logic [7:0] s_char_byte,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] m_out_byte,
    input  wire logic [1:0] m_status,
    input  wire logic       m_last,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [1:0] cfg_data,
    output int              fail_count,
    output int              pending
);

    import b64d_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } decoded_word_t;

    decoded_word_t expected_words[$];
    decoded_word_t step_words[4];
    int            step_n;

    logic [1:0]  alpha_lock;
    logic        skip_blank;
    logic        flag_errors;
    logic [5:0]  quad[4];
    int unsigned nsym;
    int unsigned npad;
    int unsigned npos;
    logic        halted;

    function automatic void push_word(input logic [7:0] d, input logic [1:0] st);
        step_words[step_n] = '{data: d, status: st, last: 1'b0};
        step_n++;
    endfunction

    function automatic void clear_group();
        nsym = 0;
        npad = 0;
        npos = 0;
    endfunction

    function automatic void halt_stream(input logic [1:0] st);
        push_word(8'h00, st);
        clear_group();
        halted = 1'b1;
    endfunction

    // pushes the bytes held by the group, returns 0 when the group cannot be decoded
    function automatic logic emit_group();
        if (nsym == 0) return 1'b1;
        if (nsym == 1) return 1'b0;
        if (nsym == 3 && quad[2][1:0] != 2'b00) return 1'b0;
        push_word({quad[0], quad[1][5:4]}, STATUS_DATA);
        if (nsym >= 3) push_word({quad[1][3:0], quad[2][5:2]}, STATUS_DATA);
        if (nsym >= 4) push_word({quad[2][1:0], quad[3]}, STATUS_DATA);
        return 1'b1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // top bit flags a symbol; an alphabet character locks the alphabet while undecided
    function automatic logic [6:0] symbol_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b1, 6'(c - 8'h41)};
        if (c >= "a" && c <= "z") return {1'b1, 6'(c - 8'h47)};
        if (c >= "0" && c <= "9") return {1'b1, 6'(c + 8'h04)};
        if (c == "+" || c == "/") begin
            if (alpha_lock == LOCK_URL) return 7'd0;
            alpha_lock = LOCK_STD;
            return {1'b1, (c == "+") ? 6'h3E : 6'h3F};
        end
        if (c == "-" || c == "_") begin
            if (alpha_lock == LOCK_STD) return 7'd0;
            alpha_lock = LOCK_URL;
            return {1'b1, (c == "-") ? 6'h3E : 6'h3F};
        end
        return 7'd0;
    endfunction

    task automatic take_char(input logic act, input logic [7:0] c);
        logic [1:0] err;
        logic [6:0] sym;
        err = flag_errors ? STATUS_ERROR : STATUS_END;
        step_n = 0;
        if (!halted) begin
            if (act == ACT_END) begin
                if (!emit_group()) halt_stream(err);
                else halt_stream((npad > 0) ? err : STATUS_END);
            end else if (skip_blank && is_blank(c)) begin
                // skipped
            end else if (c == CHAR_PAD) begin
                if (nsym < 2) begin
                    halt_stream(err);
                end else begin
                    npad++;
                    npos++;
                    if (npos >= 4) begin
                        if (emit_group()) clear_group();
                        else halt_stream(err);
                    end
                end
            end else if (npad > 0) begin
                void'(emit_group());
                halt_stream(err);
            end else begin
                sym = symbol_of(c);
                if (!sym[6]) begin
                    void'(emit_group());
                    halt_stream(err);
                end else begin
                    quad[nsym] = sym[5:0];
                    nsym++;
                    npos++;
                    if (nsym >= 4) begin
                        void'(emit_group());
                        clear_group();
                    end
                end
            end
        end
        if (step_n > 0) step_words[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) expected_words.push_back(step_words[i]);
    endtask

    task automatic apply_setting(input logic [1:0] idx, input logic [1:0] val);
        case (idx)
            REG_ALPHABET_MODE: begin
                alpha_lock = (val == MODE_STD) ? LOCK_STD :
                             (val == MODE_URL) ? LOCK_URL : LOCK_NONE;
            end
            REG_SKIP_WHITESPACE: skip_blank = val[0];
            REG_REPORT_ERRORS: flag_errors = val[0];
            default: ;
        endcase
    endtask

    task automatic check_word();
        decoded_word_t got;
        decoded_word_t want;
        got = '{data: m_out_byte, status: m_status, last: m_last};
        if (expected_words.size() == 0) begin
            if (fail_count < 10)
                $display("unexpected word: data %02h status %0d last %0b",
                         got.data, got.status, got.last);
            fail_count++;
        end else begin
            want = expected_words.pop_front();
            if (got.data !== want.data || got.status !== want.status ||
                got.last !== want.last) begin
                if (fail_count < 10)
                    $display("word mismatch: expected data %02h status %0d last %0b, %s",
                             want.data, want.status, want.last,
                             $sformatf("got data %02h status %0d last %0b",
                                       got.data, got.status, got.last));
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_words.delete();
            clear_group();
            halted = 1'b0;
            alpha_lock = LOCK_NONE;
            skip_blank = 1'b0;
            flag_errors = 1'b0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) check_word();
            if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);
            if (s_valid && s_ready) take_char(s_action, s_char_byte);
        end
        pending <= expected_words.size();
    end

endmodule

/* verif/base64_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// base64_stream_decoder_tb: clock, reset, character and register stimulus, receiver stalls
// depends on b64d_pkg, base64_stream_decoder and base64_stream_decoder_checker

module base64_stream_decoder_tb;

    import b64d_pkg::*;

    localparam logic       ACT_CHAR      = 1'b0;
    localparam logic [1:0] MODE_AUTO     = 2'd0;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef enum int {
        STOP_EOS,
        STOP_SHORT_PAD,
        STOP_BAD_CHAR,
        STOP_SPACE,
        STOP_EARLY_PAD,
        STOP_LOW_BITS,
        STOP_AFTER_PAD,
        STOP_WRONG_ALPHABET
    } stop_kind_t;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic       s_action    = ACT_CHAR;
    logic [7:0] s_char_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic [1:0] m_status;
    logic       m_last;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index   = REG_ALPHABET_MODE;
    logic [1:0] cfg_data    = MODE_AUTO;
    int         fail_count;
    int         pending;

    logic        long_hold_req  = 1'b0;
    logic        long_hold_done = 1'b0;
    int          hold_left      = 0;
    int          style_left     = 0;
    stall_mode_t stall_style    = STALL_NONE;
    logic [2:0]  beat           = 3'd0;
    int          burst_left     = 0;

    base64_stream_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_char_byte (s_char_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_status    (m_status),
        .m_last      (m_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    base64_stream_decoder_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_char_byte (s_char_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_status    (m_status),
        .m_last      (m_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        beat <= beat + 3'd1;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            style_left <= 0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            m_ready <= 1'b0;
            hold_left <= 90;
            long_hold_done <= 1'b1;
        end else begin
            if (style_left == 0) begin
                stall_style <= stall_mode_t'($urandom_range(0, 3));
                style_left <= $urandom_range(16, 96);
            end else begin
                style_left <= style_left - 1;
            end
            case (stall_style)
                STALL_NONE: m_ready <= 1'b1;
                STALL_HALF: m_ready <= 1'($urandom_range(0, 1));
                STALL_HEAVY: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (beat != 3'd0);
            endcase
        end
    end

    function automatic logic [7:0] code_char(input logic [5:0] v, input logic url);
        if (v < 6'd26) return 8'(v) + 8'h41;
        if (v < 6'd52) return 8'(v) + 8'h47;
        if (v < 6'd62) return 8'(v) - 8'h04;
        if (v == 6'h3E) return url ? "-" : "+";
        return url ? "_" : "/";
    endfunction

    function automatic logic [7:0] blank_char(input int k);
        case (k)
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic is_code_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "+" || c == "/" ||
               c == "-" || c == "_" || c == CHAR_PAD;
    endfunction

    function automatic logic [5:0] pick_symbol();
        case ($urandom_range(0, 7))
            0: return 6'h00;
            1: return 6'h3F;
            2: return 6'h3E;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic send_word(input logic act, input logic [7:0] c);
        int  gap;
        logic took;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_char_byte <= c;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        burst_left--;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_word(ACT_CHAR, txt[i]);
    endtask

    task automatic send_char_item(input logic [7:0] c, input logic ws);
        if (ws && $urandom_range(0, 4) == 0)
            send_word(ACT_CHAR, blank_char($urandom_range(0, 5)));
        send_word(ACT_CHAR, c);
    endtask

    task automatic send_symbols(input int n, input logic url);
        for (int i = 0; i < n; i++) send_word(ACT_CHAR, code_char(pick_symbol(), url));
    endtask

    // full group, two symbols with two pads, or three symbols with one pad
    task automatic send_group(input logic url, input logic ws);
        int         shape;
        logic [5:0] v2;
        shape = $urandom_range(0, 7);
        v2 = pick_symbol();
        send_char_item(code_char(pick_symbol(), url), ws);
        send_char_item(code_char(pick_symbol(), url), ws);
        if (shape == 6) begin
            send_char_item(CHAR_PAD, ws);
            send_char_item(CHAR_PAD, ws);
        end else if (shape == 7) begin
            send_char_item(code_char({v2[5:2], 2'b00}, url), ws);
            send_char_item(CHAR_PAD, ws);
        end else begin
            send_char_item(code_char(v2, url), ws);
            send_char_item(code_char(pick_symbol(), url), ws);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
    endtask

    task automatic write_settings(input logic [1:0] mode, input logic ws, input logic rep);
        write_reg(REG_ALPHABET_MODE, mode);
        write_reg(REG_SKIP_WHITESPACE, {1'b0, ws});
        write_reg(REG_REPORT_ERRORS, {1'b0, rep});
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    // one way of ending the stream, after which every word is ignored
    task automatic stop_stream();
        stop_kind_t kind;
        logic [1:0] mode;
        logic       ws;
        logic       rep;
        logic       url;
        logic [7:0] c;
        kind = stop_kind_t'($urandom_range(0, 7));
        mode = 2'($urandom_range(0, 3));
        ws = (kind == STOP_SPACE) ? 1'b0 : 1'($urandom_range(0, 1));
        rep = 1'($urandom_range(0, 1));
        url = (mode == MODE_URL) || ((mode != MODE_STD) && $urandom_range(0, 1));
        drain();
        write_settings(mode, ws, rep);
        case (kind)
            STOP_EOS: begin
                send_symbols($urandom_range(0, 3), url);
                send_word(ACT_END, 8'h00);
            end
            STOP_SHORT_PAD: begin
                send_symbols(2, url);
                send_word(ACT_CHAR, CHAR_PAD);
                send_word(ACT_END, 8'h00);
            end
            STOP_BAD_CHAR: begin
                do c = 8'($urandom_range(0, 255));
                while (is_code_char(c) || (ws && c <= 8'h20));
                send_symbols($urandom_range(0, 3), url);
                send_word(ACT_CHAR, c);
            end
            STOP_SPACE: begin
                send_symbols($urandom_range(0, 3), url);
                send_word(ACT_CHAR, blank_char($urandom_range(0, 5)));
            end
            STOP_EARLY_PAD: begin
                send_symbols($urandom_range(0, 1), url);
                send_word(ACT_CHAR, CHAR_PAD);
            end
            STOP_LOW_BITS: begin
                send_symbols(2, url);
                c = code_char({4'($urandom_range(0, 15)), 2'($urandom_range(1, 3))}, url);
                send_word(ACT_CHAR, c);
                send_word(ACT_CHAR, CHAR_PAD);
            end
            STOP_AFTER_PAD: begin
                send_symbols(2, url);
                send_word(ACT_CHAR, CHAR_PAD);
                send_word(ACT_CHAR, code_char(pick_symbol(), url));
            end
            default: begin
                send_word(ACT_CHAR, code_char(6'h3E, url));
                send_word(ACT_CHAR, code_char(6'h3F, !url));
            end
        endcase
    endtask

    initial begin
        int         p;
        logic [1:0] mode;
        logic       url;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_settings(MODE_AUTO, 1'b0, 1'b1);
        send_text("AAAA////TQ==TWE=");
        drain();
        write_settings(MODE_URL, 1'b1, 1'b0);
        send_text("_-");
        for (int k = 0; k < 6; k++) send_word(ACT_CHAR, blank_char(k));
        send_text("A9");

        for (p = 0; p < 5; p++) begin
            drain();
            mode = 2'(p % 4);
            write_settings(mode, p[0], p[1]);
            url = (mode == MODE_URL) || ((mode != MODE_STD) && $urandom_range(0, 1));
            if (p == 2) long_hold_req <= 1'b1;
            for (int g = 0; g < 7; g++) send_group(url, p[0]);
        end

        stop_stream();
        for (int k = 0; k < 20; k++)
            send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        drain();
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
